// ----- src/profile_stats_table_assert.svh -----
// Assertion helpers for the profiling table RTL.
// Every check samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef PROFILE_STATS_TABLE_ASSERT_SVH
`define PROFILE_STATS_TABLE_ASSERT_SVH

// Check a property on every clock edge.
`define PST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition leads to a result in the following cycle.
`define PST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pst_pkg.sv -----
package pst_pkg;

  // Default table depth.
  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // Request codes carried in s_axis_tuser.
  typedef enum logic [1:0] {
    OP_COUNT_CALL    = 2'd0,
    OP_RECORD_SAMPLE = 2'd1,
    OP_READ_ENTRY    = 2'd2,
    OP_CLEAR_ALL     = 2'd3
  } op_e;

  // Status codes carried in m_axis_tuser.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NULL_KEY  = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_e;

  // Countdown timer: counts per timer period.
  localparam int unsigned COUNT_W = 14;
  localparam logic [COUNT_W-1:0] TICK_PERIOD = 14'd11932;

  // Offset in us is (period - count) * 1000000 / 1193180, taken as
  // (period - count) * TICK_RECIP >> TICK_SHIFT. The reciprocal is rounded up
  // and exact for every remaining count up to the period.
  localparam int unsigned TICK_RECIP_W = 30;
  localparam logic [TICK_RECIP_W-1:0] TICK_RECIP = 30'd899899281;
  localparam int unsigned TICK_SHIFT = 30;

  // The offset never exceeds 10000 us, so 14 bits are enough.
  localparam int unsigned OFFSET_W = 14;

  // Milliseconds to microseconds.
  localparam logic [9:0] US_PER_MS = 10'd1000;

endpackage

// ----- src/pst_tick_div.sv -----
// Timer offset unit: clamps a latched countdown value to the period and turns
// the remaining counts into microseconds with one multiply by a scaled
// reciprocal of the timer clock. The offset is ready the cycle after start.
module pst_tick_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pst_pkg::COUNT_W-1:0]       count_i,
  output logic                              done_o,
  output logic [pst_pkg::OFFSET_W-1:0]      offset_o
);

  localparam int unsigned PW = pst_pkg::COUNT_W + pst_pkg::TICK_RECIP_W;

  logic                         done_q;
  logic [pst_pkg::OFFSET_W-1:0] offset_q;

  logic [pst_pkg::COUNT_W-1:0] cnt_clamp;
  logic [pst_pkg::COUNT_W-1:0] remain;
  logic [PW-1:0]               prod;

  // Clamp the count and scale the remaining counts.
  always_comb begin
    cnt_clamp = (count_i > pst_pkg::TICK_PERIOD) ? pst_pkg::TICK_PERIOD : count_i;
    remain    = pst_pkg::TICK_PERIOD - cnt_clamp;
    prod      = PW'(remain) * PW'(pst_pkg::TICK_RECIP);
  end

  // Flag the offset in the cycle after start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // Datapath register carries no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      offset_q <= prod[pst_pkg::TICK_SHIFT +: pst_pkg::OFFSET_W];
    end
  end

  assign done_o   = done_q;
  assign offset_o = offset_q;

endmodule

// ----- src/profile_stats_table.sv -----
// Count call and record sample scan the entries in use for the key, one table entry
// per cycle; record sample first works out the duration in microseconds from the
// start and end stamps. Read entry checks the index before it reads the entry, and
// clear all goes straight to the output. One request at a time: the next is taken
// the cycle after the result loads, later while the output stalls.
// Reset is asynchronous, active low: it empties the table and zeroes both totals.
`include "profile_stats_table_assert.svh"

module profile_stats_table #(
  parameter int unsigned MAX_ENTRIES = pst_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // name_key[31:0], start_ms[63:32], start_count[77:64], end_ms[109:78],
  // end_count[123:110], entry_index[129:124], zero fill [135:130]
  input  logic [135:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_key[31:0], call_count[63:32], timed_count[95:64],
  // last_duration[127:96], total_duration[159:128], max_duration[191:160],
  // entries_in_use[198:192], samples_written[230:199],
  // samples_dropped[262:231], duration_us[294:263], zero fill [295]
  output logic [295:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned OW = pst_pkg::OFFSET_W;
  localparam int unsigned KW = pst_pkg::COUNT_W;
  localparam int unsigned BW = 42;
  localparam int unsigned TW = BW + 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_OFF_END,
    ST_OFF_START,
    ST_SUM,
    ST_CHECK,
    ST_LOOKUP,
    ST_UPDATE,
    ST_READ,
    ST_READ_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] calls;
    logic [31:0] timed;
    logic [31:0] last;
    logic [31:0] total;
    logic [31:0] max;
  } entry_t;

  state_e        state_q;

  // Captured request.
  pst_pkg::op_e  op_q;
  logic [31:0]   key_q;
  logic [31:0]   start_ms_q;
  logic [KW-1:0] start_cnt_q;
  logic [31:0]   end_ms_q;
  logic [KW-1:0] end_cnt_q;
  logic [5:0]    idx_q;

  // Duration path.
  logic [31:0]   diff_q;
  logic [BW-1:0] base_q;
  logic [OW-1:0] off_end_q;
  logic [OW-1:0] off_start_q;
  logic [31:0]   dur_q;

  // Scan and update.
  logic [CW-1:0] scan_q;
  logic          pend_q;
  logic [AW-1:0] pidx_q;
  logic [AW-1:0] slot_q;
  logic          alloc_q;
  entry_t        ent_q;

  // Totals.
  logic [CW-1:0] used_q;
  logic [31:0]   written_q;
  logic [31:0]   dropped_q;

  // Result waiting for the output register.
  pst_pkg::status_e res_status_q;
  entry_t           res_ent_q;

  // Output register.
  logic          m_valid_q;
  logic [295:0]  m_data_q;
  logic [1:0]    m_user_q;

  // Table memory.
  entry_t        mem [MAX_ENTRIES];
  entry_t        mem_rd_q;
  logic [AW-1:0] rd_addr;

  // Divider hookup.
  logic          div_start;
  logic [KW-1:0] div_count;
  logic          div_done;
  logic [OW-1:0] div_offset;

  logic                 accept;
  logic signed [TW-1:0] total_s;
  logic [31:0]          dur_clamp;
  entry_t               upd;
  logic                 hit;
  logic                 out_free;

  assign accept   = s_axis_tvalid && (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_axis_tready;

  // Shared offset unit: end count first, then start count.
  assign div_start = (state_q == ST_MUL) || ((state_q == ST_OFF_END) && div_done);
  assign div_count = (state_q == ST_MUL) ? end_cnt_q : start_cnt_q;

  pst_tick_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .count_i  (div_count),
    .done_o   (div_done),
    .offset_o (div_offset)
  );

  // Combine base and offsets, clamp to the 32-bit range.
  always_comb begin
    total_s = $signed({2'b00, base_q}) + $signed(TW'(off_end_q))
            - $signed(TW'(off_start_q));
    if (total_s < 0) begin
      dur_clamp = '0;
    end else if (total_s > $signed(TW'(32'hFFFF_FFFF))) begin
      dur_clamp = 32'hFFFF_FFFF;
    end else begin
      dur_clamp = total_s[31:0];
    end
  end

  // Bump the selected entry.
  always_comb begin
    upd = ent_q;
    if (op_q == pst_pkg::OP_COUNT_CALL) begin
      upd.calls = ent_q.calls + 32'd1;
    end else begin
      upd.timed = ent_q.timed + 32'd1;
      upd.last  = dur_q;
      upd.total = ent_q.total + dur_q;
      if (dur_q > ent_q.max) begin
        upd.max = dur_q;
      end
    end
  end

  assign hit     = pend_q && (mem_rd_q.key == key_q);
  assign rd_addr = (state_q == ST_READ) ? AW'(idx_q) : scan_q[AW-1:0];

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      mem[slot_q] <= upd;
    end
    mem_rd_q <= mem[rd_addr];
  end

  // Sequencer with control state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      written_q <= '0;
      dropped_q <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads in the same cycle.
      if (m_axis_tready && !((state_q == ST_OUT) && out_free)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            dur_q <= '0;
            unique case (pst_pkg::op_e'(s_axis_tuser[1:0]))
              pst_pkg::OP_COUNT_CALL:    state_q <= ST_CHECK;
              pst_pkg::OP_RECORD_SAMPLE: state_q <= ST_DIFF;
              pst_pkg::OP_READ_ENTRY:    state_q <= ST_READ;
              pst_pkg::OP_CLEAR_ALL: begin
                used_q       <= '0;
                written_q    <= '0;
                dropped_q    <= '0;
                res_status_q <= pst_pkg::STAT_OK;
                res_ent_q    <= '0;
                state_q      <= ST_OUT;
              end
              default:          state_q <= ST_IDLE;
            endcase
          end
        end
        ST_DIFF: begin
          diff_q  <= (end_ms_q >= start_ms_q) ? (end_ms_q - start_ms_q) : '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          base_q  <= BW'(diff_q) * BW'(pst_pkg::US_PER_MS);
          state_q <= ST_OFF_END;
        end
        ST_OFF_END: begin
          if (div_done) begin
            off_end_q <= div_offset;
            state_q   <= ST_OFF_START;
          end
        end
        ST_OFF_START: begin
          if (div_done) begin
            off_start_q <= div_offset;
            state_q     <= ST_SUM;
          end
        end
        ST_SUM: begin
          dur_q   <= dur_clamp;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (key_q == '0) begin
            res_status_q <= pst_pkg::STAT_NULL_KEY;
            res_ent_q    <= '0;
            state_q      <= ST_OUT;
          end else begin
            scan_q  <= '0;
            pend_q  <= 1'b0;
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (hit) begin
            slot_q  <= pidx_q;
            ent_q   <= mem_rd_q;
            alloc_q <= 1'b0;
            pend_q  <= 1'b0;
            state_q <= ST_UPDATE;
          end else if (scan_q < used_q) begin
            pidx_q <= scan_q[AW-1:0];
            pend_q <= 1'b1;
            scan_q <= scan_q + CW'(1);
          end else begin
            pend_q <= 1'b0;
            if (used_q == CW'(MAX_ENTRIES)) begin
              // Table full: count the drop once.
              dropped_q    <= dropped_q + 32'd1;
              res_status_q <= pst_pkg::STAT_FULL;
              res_ent_q    <= '0;
              state_q      <= ST_OUT;
            end else begin
              slot_q    <= used_q[AW-1:0];
              ent_q     <= {key_q, 160'd0};
              alloc_q   <= 1'b1;
              state_q   <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          if (alloc_q) begin
            used_q <= used_q + CW'(1);
          end
          if (op_q == pst_pkg::OP_RECORD_SAMPLE) begin
            written_q <= written_q + 32'd1;
          end
          res_status_q <= pst_pkg::STAT_OK;
          res_ent_q    <= upd;
          state_q      <= ST_OUT;
        end
        ST_READ: begin
          if (32'(idx_q) < 32'(used_q)) begin
            state_q <= ST_READ_WAIT;
          end else begin
            res_status_q <= pst_pkg::STAT_BAD_INDEX;
            res_ent_q    <= '0;
            state_q      <= ST_OUT;
          end
        end
        ST_READ_WAIT: begin
          res_status_q <= pst_pkg::STAT_OK;
          res_ent_q    <= mem_rd_q;
          state_q      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_status_q;
            m_data_q  <= {1'b0, dur_q, dropped_q, written_q, 7'(used_q),
                          res_ent_q.max, res_ent_q.total, res_ent_q.last,
                          res_ent_q.timed, res_ent_q.calls, res_ent_q.key};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Capture the request payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= pst_pkg::op_e'(s_axis_tuser[1:0]);
      key_q       <= s_axis_tdata[31:0];
      start_ms_q  <= s_axis_tdata[63:32];
      start_cnt_q <= s_axis_tdata[77:64];
      end_ms_q    <= s_axis_tdata[109:78];
      end_cnt_q   <= s_axis_tdata[123:110];
      idx_q       <= s_axis_tdata[129:124];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `PST_ASSERT(a_used_bound, used_q <= CW'(MAX_ENTRIES), "entry count above table depth")
  `PST_ASSERT(a_scan_bound, (state_q != ST_LOOKUP) || (scan_q <= used_q), "scan past used entries")
  `PST_ASSERT_NEXT(a_out_load, (state_q == ST_OUT) && out_free, m_valid_q && (state_q == ST_IDLE), "result not loaded")
  `PST_ASSERT_NEXT(a_totals_hold, (state_q != ST_UPDATE) && (state_q != ST_IDLE), $stable(used_q) && $stable(written_q), "totals changed outside update")

endmodule
